[hdl/lag_pkg.sv]
// ----------------------------------------------------------------------------
// lag_pkg
// Shared sizes, codes and controller/datapath interface types for the
// B3/S23 life board.
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int ROWS   = 64;
  localparam int COLS   = 64;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int COL_AW = $clog2(COLS);
  localparam int ROW_CW = $clog2(ROWS + 1);
  // coordinate fields are 6 bits; widened so any board size compares cleanly
  localparam int ROW_XW = ROW_AW + 6;
  localparam int COL_XW = COL_AW + 6;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    WS_CLEAR,
    WS_GEN,
    WS_CELL
  } wsel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_CELL,
    ST_GEN_INIT,
    ST_GEN_FIRST,
    ST_GEN_RUN,
    ST_GEN_TAIL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  item_load;
    logic  decode;
    logic  rd_en;
    logic  rd_item;
    logic  gen_start;
    logic  gen_shift;
    logic  gen_tail;
    logic  wr_en;
    wsel_t wr_sel;
    logic  cell_capture;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic is_access;
    logic in_range;
    logic is_advance;
    logic scan_done;
    logic wrow_last;
    logic out_free;
  } status_t;

endpackage

[hdl/lag_ctrl.sv]
// ----------------------------------------------------------------------------
// lag_ctrl
// Sequencer for the life board: reset clear sweep, cell access and the
// row-by-row generation sweep.
// ----------------------------------------------------------------------------
module lag_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lag_pkg::status_t status,
  output lag_pkg::cmd_t    cmd
);

  lag_pkg::state_t state;
  lag_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lag_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != lag_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      lag_pkg::ST_CLEAR: begin
        if (status.wrow_last) state_next = lag_pkg::ST_IDLE;
      end
      lag_pkg::ST_IDLE: begin
        if (in_valid) state_next = lag_pkg::ST_DECODE;
      end
      lag_pkg::ST_DECODE: begin
        if (status.is_access && status.in_range) begin
          state_next = lag_pkg::ST_CELL;
        end else if (status.is_advance) begin
          state_next = lag_pkg::ST_GEN_INIT;
        end else begin
          state_next = lag_pkg::ST_DONE;
        end
      end
      lag_pkg::ST_CELL:      state_next = lag_pkg::ST_DONE;
      lag_pkg::ST_GEN_INIT:  state_next = lag_pkg::ST_GEN_FIRST;
      lag_pkg::ST_GEN_FIRST: state_next = lag_pkg::ST_GEN_RUN;
      lag_pkg::ST_GEN_RUN: begin
        if (status.scan_done) state_next = lag_pkg::ST_GEN_TAIL;
      end
      lag_pkg::ST_GEN_TAIL:  state_next = lag_pkg::ST_DONE;
      lag_pkg::ST_DONE: begin
        if (status.out_free) state_next = lag_pkg::ST_IDLE;
      end
      default: state_next = lag_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.wr_sel = lag_pkg::WS_GEN;
    case (state)
      lag_pkg::ST_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = lag_pkg::WS_CLEAR;
      end
      lag_pkg::ST_IDLE: begin
        cmd.item_load = in_valid;
      end
      lag_pkg::ST_DECODE: begin
        cmd.decode    = 1'b1;
        cmd.rd_en     = status.is_access && status.in_range;
        cmd.rd_item   = 1'b1;
        cmd.gen_start = status.is_advance;
      end
      lag_pkg::ST_CELL: begin
        // write is a read-modify-write of the whole row
        cmd.cell_capture = 1'b1;
        cmd.wr_sel       = lag_pkg::WS_CELL;
      end
      lag_pkg::ST_GEN_INIT: begin
        cmd.rd_en = 1'b1;
      end
      lag_pkg::ST_GEN_FIRST: begin
        cmd.gen_shift = 1'b1;
        cmd.rd_en     = !status.scan_done;
      end
      lag_pkg::ST_GEN_RUN: begin
        cmd.gen_shift = 1'b1;
        cmd.wr_en     = 1'b1;
        cmd.rd_en     = !status.scan_done;
      end
      lag_pkg::ST_GEN_TAIL: begin
        cmd.gen_tail = 1'b1;
        cmd.wr_en    = 1'b1;
      end
      lag_pkg::ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[hdl/lag_datapath.sv]
// ----------------------------------------------------------------------------
// lag_datapath
// Row-wide board memory, item registers, three-row window with the B3/S23
// rule applied across a full row, and the result register.
// ----------------------------------------------------------------------------
module lag_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       operation,
  input  logic [5:0]       cell_row,
  input  logic [5:0]       cell_col,
  input  logic             cell_value,
  output logic             cell_state,
  output logic             out_of_range,
  output logic             out_valid,
  input  logic             out_stall,
  input  lag_pkg::cmd_t    cmd,
  output lag_pkg::status_t status
);

  // one row of the board per word
  logic [lag_pkg::COLS-1:0] board [lag_pkg::ROWS];
  logic [lag_pkg::COLS-1:0] rdata;

  logic [1:0] item_op;
  logic [5:0] item_row;
  logic [5:0] item_col;
  logic       item_val;

  logic [lag_pkg::ROW_XW-1:0] row_ext;
  logic [lag_pkg::COL_XW-1:0] col_ext;
  logic [lag_pkg::ROW_AW-1:0] row_idx;
  logic [lag_pkg::COL_AW-1:0] col_idx;

  logic [lag_pkg::ROW_CW-1:0] scan;
  logic [lag_pkg::ROW_AW-1:0] wrow;
  logic [lag_pkg::COLS-1:0]   prev;
  logic [lag_pkg::COLS-1:0]   cur;
  logic [lag_pkg::COLS-1:0]   below;
  logic [lag_pkg::COLS-1:0]   gen_row;
  logic [lag_pkg::COLS-1:0]   cell_row_mod;

  logic [lag_pkg::ROW_AW-1:0] raddr;
  logic [lag_pkg::ROW_AW-1:0] waddr;
  logic [lag_pkg::COLS-1:0]   wdata;
  logic                       wr_en;

  logic res_state;
  logic res_oor;

  function automatic logic [lag_pkg::COLS-1:0] life_row(
    input logic [lag_pkg::COLS-1:0] up,
    input logic [lag_pkg::COLS-1:0] mid,
    input logic [lag_pkg::COLS-1:0] dn
  );
    logic [lag_pkg::COLS+1:0] u;
    logic [lag_pkg::COLS+1:0] m;
    logic [lag_pkg::COLS+1:0] d;
    logic [3:0]               n;
    logic [lag_pkg::COLS-1:0] res;
    // zero pad: cells off the board are dead
    u = {1'b0, up, 1'b0};
    m = {1'b0, mid, 1'b0};
    d = {1'b0, dn, 1'b0};
    for (int j = 0; j < lag_pkg::COLS; j++) begin
      n = 4'(u[j]) + 4'(u[j+1]) + 4'(u[j+2]) + 4'(m[j]) + 4'(m[j+2])
        + 4'(d[j]) + 4'(d[j+1]) + 4'(d[j+2]);
      res[j] = (n == 4'd3) || (mid[j] && (n == 4'd2));
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_op  <= operation;
      item_row <= cell_row;
      item_col <= cell_col;
      item_val <= cell_value;
    end
  end

  assign row_ext = lag_pkg::ROW_XW'(item_row);
  assign col_ext = lag_pkg::COL_XW'(item_col);
  assign row_idx = row_ext[lag_pkg::ROW_AW-1:0];
  assign col_idx = col_ext[lag_pkg::COL_AW-1:0];

  assign status.is_access  = (item_op == lag_pkg::OP_WRITE) || (item_op == lag_pkg::OP_READ);
  assign status.in_range   = (row_ext < lag_pkg::ROW_XW'(lag_pkg::ROWS)) &&
                             (col_ext < lag_pkg::COL_XW'(lag_pkg::COLS));
  assign status.is_advance = (item_op == lag_pkg::OP_ADVANCE);
  assign status.scan_done  = (scan == lag_pkg::ROW_CW'(lag_pkg::ROWS));
  assign status.wrow_last  = (wrow == lag_pkg::ROW_AW'(lag_pkg::ROWS - 1));
  assign status.out_free   = !out_valid || !out_stall;

  // scan: next row to read; wrow: next row to write (clear or generation)
  always_ff @(posedge clk) begin
    if (rst || cmd.gen_start) begin
      scan <= '0;
      wrow <= '0;
    end else begin
      if (cmd.rd_en && !cmd.rd_item) scan <= scan + 1'b1;
      if (wr_en && (cmd.wr_sel != lag_pkg::WS_CELL)) wrow <= wrow + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_start) begin
      prev <= '0;
      cur  <= '0;
    end else if (cmd.gen_shift) begin
      prev <= cur;
      cur  <= rdata;
    end
  end

  assign below   = cmd.gen_tail ? '0 : rdata;
  assign gen_row = life_row(prev, cur, below);

  always_comb begin
    cell_row_mod          = rdata;
    cell_row_mod[col_idx] = item_val;
  end

  assign raddr = cmd.rd_item ? row_idx : scan[lag_pkg::ROW_AW-1:0];
  assign wr_en = cmd.wr_en || (cmd.cell_capture && (item_op == lag_pkg::OP_WRITE));

  always_comb begin
    waddr = wrow;
    case (cmd.wr_sel)
      lag_pkg::WS_CLEAR: wdata = '0;
      lag_pkg::WS_GEN:   wdata = gen_row;
      lag_pkg::WS_CELL: begin
        wdata = cell_row_mod;
        waddr = row_idx;
      end
      default:           wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) board[waddr] <= wdata;
    if (cmd.rd_en) rdata <= board[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_state <= 1'b0;
      res_oor   <= status.is_access && !status.in_range;
    end else if (cmd.cell_capture && (item_op == lag_pkg::OP_READ)) begin
      res_state <= rdata[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_state   <= res_state;
      out_of_range <= res_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hdl/life_automaton_generation.sv]
// ----------------------------------------------------------------------------
// life_automaton_generation
// Life board (B3/S23, dead border) with cell write, cell read and
// single-generation advance.
//
//   channel | handshake            | fields
//   input   | in_valid, in_stall   | operation, cell_row, cell_col, cell_value
//   output  | out_valid, out_stall | cell_state, out_of_range
//
// Read or write: decode with row read, cell step, result register (no cell
// step when out of range or the operation is unused). Advance: the board one
// row per memory word, read once per row, each new row from a three-row
// window. After reset a clear sweep writes all ROWS rows, in_stall high.
// One transaction in flight at a time; in_stall stays high until the result
// register takes the result, so a held out_stall also holds off the input.
// ----------------------------------------------------------------------------
module life_automaton_generation (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [5:0] cell_row,
  input  logic [5:0] cell_col,
  input  logic       cell_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       cell_state,
  output logic       out_of_range
);

  lag_pkg::cmd_t    cmd;
  lag_pkg::status_t status;

  lag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lag_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .operation    (operation),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .cell_value   (cell_value),
    .cell_state   (cell_state),
    .out_of_range (out_of_range),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the B3/S23 life board. Cell writes, cell reads and
// generation steps run against a shadow copy of the board kept in the bench.
// Both channels see random idle and stall gaps, with one long output
// hold-off so that the input side backs up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 250;
  localparam int ITEM_TARGET = 140;

  typedef struct {
    logic [1:0] op;
    logic [5:0] row;
    logic [5:0] col;
    logic       val;
  } cell_cmd_t;

  typedef struct {
    logic state;
    logic oor;
  } cell_answer_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] operation = lag_pkg::OP_WRITE;
  logic [5:0] cell_row = '0;
  logic [5:0] cell_col = '0;
  logic       cell_value = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       cell_state;
  logic       out_of_range;

  cell_cmd_t    pending_cmds[$];
  cell_answer_t cell_answers[$];
  bit           shadow_board [lag_pkg::ROWS][lag_pkg::COLS];
  int           errors = 0;
  int           send_gap = 0;
  int           send_calm = 0;
  int           stall_left = 0;
  int           recv_calm = 0;
  int           hold_left = 0;
  int           results_seen = 0;
  int           idle_cycles = 0;

  life_automaton_generation i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .cell_value   (cell_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cell_state   (cell_state),
    .out_of_range (out_of_range)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int p;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 3) begin
      calm = 25;
      return 0;
    end
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int live_around(int r, int c);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < lag_pkg::ROWS &&
            c + dc >= 0 && c + dc < lag_pkg::COLS) begin
          n += shadow_board[r + dr][c + dc];
        end
      end
    end
    return n;
  endfunction

  task automatic step_generation();
    bit fresh [lag_pkg::ROWS][lag_pkg::COLS];
    int n;
    for (int r = 0; r < lag_pkg::ROWS; r++) begin
      for (int c = 0; c < lag_pkg::COLS; c++) begin
        n = live_around(r, c);
        fresh[r][c] = shadow_board[r][c] ? (n == 2 || n == 3) : (n == 3);
      end
    end
    shadow_board = fresh;
  endtask

  task automatic predict_cell_answer(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                                     logic val);
    cell_answer_t ans;
    ans.state = 1'b0;
    ans.oor   = 1'b0;
    if (op == lag_pkg::OP_WRITE || op == lag_pkg::OP_READ) begin
      if (int'(row) >= lag_pkg::ROWS || int'(col) >= lag_pkg::COLS) begin
        ans.oor = 1'b1;
      end else if (op == lag_pkg::OP_WRITE) begin
        shadow_board[row][col] = val;
      end else begin
        ans.state = shadow_board[row][col];
      end
    end else if (op == lag_pkg::OP_ADVANCE) begin
      step_generation();
    end
    cell_answers.push_back(ans);
  endtask

  task automatic queue_cmd(logic [1:0] op, int row, int col, logic val);
    cell_cmd_t cmd;
    cmd.op  = op;
    cmd.row = row[5:0];
    cmd.col = col[5:0];
    cmd.val = val;
    pending_cmds.push_back(cmd);
  endtask

  // edges of the board show up often so the dead border gets exercised
  function automatic int pick_base();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 60;
      default: return $urandom_range(0, 60);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    cell_cmd_t nxt;
    logic      take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        predict_cell_answer(operation, cell_row, cell_col, cell_value);
      end
      if (in_valid && !take) begin
        // stalled transaction: hold payload
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        nxt = pending_cmds.pop_front();
        operation  <= nxt.op;
        cell_row   <= nxt.row;
        cell_col   <= nxt.col;
        cell_value <= nxt.val;
        in_valid   <= 1'b1;
        send_gap   = pick_gap(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    cell_answer_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cell_answers.size() == 0) begin
          errors++;
          $display("%t unexpected result: expected none, actual state=%b oor=%b",
                   $time, cell_state, out_of_range);
        end else begin
          want = cell_answers.pop_front();
          if (cell_state !== want.state) begin
            errors++;
            $display("%t cell_state mismatch: expected %b actual %b",
                     $time, want.state, cell_state);
          end
          if (out_of_range !== want.oor) begin
            errors++;
            $display("%t out_of_range mismatch: expected %b actual %b",
                     $time, want.oor, out_of_range);
          end
        end
        results_seen++;
        if (results_seen == 40) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(recv_calm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%t timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int br;
    int bc;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // corners
    queue_cmd(lag_pkg::OP_WRITE, 0, 0, 1'b1);
    queue_cmd(lag_pkg::OP_WRITE, 63, 63, 1'b1);
    queue_cmd(lag_pkg::OP_WRITE, 0, 63, 1'b1);
    queue_cmd(lag_pkg::OP_WRITE, 63, 0, 1'b1);
    queue_cmd(lag_pkg::OP_READ, 0, 0, 1'b0);
    queue_cmd(lag_pkg::OP_READ, 63, 63, 1'b1);
    queue_cmd(lag_pkg::OP_READ, 0, 63, 1'b0);
    queue_cmd(lag_pkg::OP_READ, 63, 0, 1'b1);
    // lone corner cells die; fields of an advance are don't-care
    queue_cmd(lag_pkg::OP_ADVANCE, 63, 63, 1'b1);
    queue_cmd(lag_pkg::OP_READ, 0, 0, 1'b1);
    // blinker flips to vertical
    queue_cmd(lag_pkg::OP_WRITE, 10, 9, 1'b1);
    queue_cmd(lag_pkg::OP_WRITE, 10, 10, 1'b1);
    queue_cmd(lag_pkg::OP_WRITE, 10, 11, 1'b1);
    queue_cmd(lag_pkg::OP_ADVANCE, 0, 0, 1'b0);
    queue_cmd(lag_pkg::OP_READ, 9, 10, 1'b0);
    queue_cmd(lag_pkg::OP_READ, 10, 10, 1'b1);
    queue_cmd(lag_pkg::OP_READ, 11, 10, 1'b0);
    queue_cmd(lag_pkg::OP_READ, 10, 9, 1'b1);
    // unused opcode changes nothing
    queue_cmd(OP_UNUSED, 63, 0, 1'b1);
    queue_cmd(OP_UNUSED, 0, 63, 1'b0);
    queue_cmd(lag_pkg::OP_WRITE, 10, 10, 1'b0);
    queue_cmd(lag_pkg::OP_READ, 10, 10, 1'b1);

    while (pending_cmds.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        // seed a small patch, let it evolve, then probe it
        br = pick_base();
        bc = pick_base();
        repeat ($urandom_range(3, 8)) begin
          queue_cmd(lag_pkg::OP_WRITE, br + $urandom_range(0, 3),
                    bc + $urandom_range(0, 3), $urandom_range(0, 4) != 0);
        end
        repeat ($urandom_range(1, 2)) begin
          queue_cmd(lag_pkg::OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                    1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(3, 6)) begin
          queue_cmd(lag_pkg::OP_READ, br + $urandom_range(0, 3),
                    bc + $urandom_range(0, 3), 1'($urandom_range(0, 1)));
        end
      end else begin
        queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      end
    end

    @(negedge clk);
    while (pending_cmds.size() > 0 || in_valid || cell_answers.size() > 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (errors == 0 && cell_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lag_pkg.sv
hdl/lag_ctrl.sv
hdl/lag_datapath.sv
hdl/life_automaton_generation.sv
test/tb_top.sv
